FILE: design/dsf_pkg.sv
`timescale 1ns / 1ps
package dsf_pkg;

    localparam int CRDW  = 32;
    localparam int DIFW  = 33;
    localparam int SQW   = 68;
    localparam int LW    = 34;
    localparam int MW    = 67;
    localparam int NW    = 100;
    localparam int QW    = 48;
    localparam int FW    = 48;
    localparam int QDEPTH = 4;
    localparam int QAW   = 2;

    localparam logic [1:0] CFG_KS   = 2'd0;
    localparam logic [1:0] CFG_KD   = 2'd1;
    localparam logic [1:0] CFG_REST = 2'd2;

    typedef struct packed {
        logic [2:0][NW-1:0] num;
        logic [2:0]         pos;
        logic [LW-1:0]      len;
        logic               stretched;
    } t_job;

endpackage

FILE: design/dsf_front.sv
`timescale 1ns / 1ps
module dsf_front import dsf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [CRDW-1:0] i_point_a_x,
    input  logic [CRDW-1:0] i_point_a_y,
    input  logic [CRDW-1:0] i_point_a_z,
    input  logic [CRDW-1:0] i_point_b_x,
    input  logic [CRDW-1:0] i_point_b_y,
    input  logic [CRDW-1:0] i_point_b_z,
    input  logic [31:0]     i_ks,
    input  logic [31:0]     i_kd,
    input  logic [31:0]     i_rest,
    input  logic            i_full,
    output logic            o_push,
    output t_job            o_job
);

    logic en;
    logic [2:0][CRDW-1:0] w_a, w_b;
    logic [2:0][DIFW-1:0] w_d, w_mag;
    logic [2:0]           w_pos;

    logic                 r_a_v, r_b_v, r_m1_v, r_m2_v, r_n1_v, r_n2_v;
    logic [2:0][DIFW-1:0] r_a_mag, r_b_mag, r_m1_mag, r_m2_mag;
    logic [2:0]           r_a_pos, r_b_pos, r_m1_pos, r_m2_pos, r_n1_pos, r_n2_pos;
    logic [2:0][65:0]     r_b_sq;

    logic [SQW-1:0]       r_s_rem  [0:LW];
    logic [LW-1:0]        r_s_root [0:LW];
    logic [2:0][DIFW-1:0] r_s_mag  [0:LW];
    logic [2:0]           r_s_pos  [0:LW];
    logic                 r_s_v    [0:LW];

    logic            w_str;
    logic [LW-1:0]   w_ext;
    logic [65:0]     r_m1_p1, r_m1_p2;
    logic [LW-1:0]   r_m1_len, r_m2_len, r_n1_len, r_n2_len;
    logic            r_m1_str, r_m2_str, r_n1_str, r_n2_str;
    logic [MW-1:0]   r_m2_m;
    logic [2:0][66:0] r_n1_lo;
    logic [2:0][65:0] r_n1_hi;
    logic [2:0][NW-1:0] r_n2_num;

    assign en      = !(r_n2_v && i_full);
    assign o_ready = en;
    assign o_push  = r_n2_v && !i_full;

    assign w_a = {i_point_a_z, i_point_a_y, i_point_a_x};
    assign w_b = {i_point_b_z, i_point_b_y, i_point_b_x};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_d[k]   = {w_a[k][CRDW-1], w_a[k]} - {w_b[k][CRDW-1], w_b[k]};
            w_mag[k] = w_d[k][DIFW-1] ? (~w_d[k] + DIFW'(1)) : w_d[k];
            w_pos[k] = !w_d[k][DIFW-1] && (w_d[k] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v    <= 1'b0;
            r_b_v    <= 1'b0;
            r_s_v[0] <= 1'b0;
        end else if (en) begin
            r_a_v    <= i_valid;
            r_b_v    <= r_a_v;
            r_s_v[0] <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_mag <= w_mag;
            r_a_pos <= w_pos;
            for (int k = 0; k < 3; k++) begin
                r_b_sq[k] <= r_a_mag[k] * r_a_mag[k];
            end
            r_b_mag     <= r_a_mag;
            r_b_pos     <= r_a_pos;
            r_s_rem[0]  <= SQW'(r_b_sq[0]) + SQW'(r_b_sq[1]) + SQW'(r_b_sq[2]);
            r_s_root[0] <= '0;
            r_s_mag[0]  <= r_b_mag;
            r_s_pos[0]  <= r_b_pos;
        end
    end

    for (genvar s = 0; s < LW; s++) begin : g_sqrt
        localparam int B = LW - 1 - s;
        logic [SQW-1:0] w_trial;
        logic           w_take;
        assign w_trial = (SQW'(r_s_root[s]) << (B + 1)) | (SQW'(1) << (2 * B));
        assign w_take  = r_s_rem[s] >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_v[s+1] <= 1'b0;
            end else if (en) begin
                r_s_v[s+1] <= r_s_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s_rem[s+1]  <= w_take ? (r_s_rem[s] - w_trial) : r_s_rem[s];
                r_s_root[s+1] <= w_take ? (r_s_root[s] | (LW'(1) << B)) : r_s_root[s];
                r_s_mag[s+1]  <= r_s_mag[s];
                r_s_pos[s+1]  <= r_s_pos[s];
            end
        end
    end

    assign w_str = r_s_root[LW] > LW'(i_rest);
    assign w_ext = w_str ? (r_s_root[LW] - LW'(i_rest)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_n1_v <= 1'b0;
            r_n2_v <= 1'b0;
        end else if (en) begin
            r_m1_v <= r_s_v[LW];
            r_m2_v <= r_m1_v;
            r_n1_v <= r_m2_v;
            r_n2_v <= r_n1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_p1  <= i_ks * w_ext;
            r_m1_p2  <= i_kd * r_s_root[LW];
            r_m1_len <= r_s_root[LW];
            r_m1_str <= w_str;
            r_m1_mag <= r_s_mag[LW];
            r_m1_pos <= r_s_pos[LW];

            r_m2_m   <= MW'(r_m1_p1) + MW'(r_m1_p2);
            r_m2_len <= r_m1_len;
            r_m2_str <= r_m1_str;
            r_m2_mag <= r_m1_mag;
            r_m2_pos <= r_m1_pos;

            for (int k = 0; k < 3; k++) begin
                r_n1_lo[k] <= r_m2_m[LW-1:0] * r_m2_mag[k];
                r_n1_hi[k] <= r_m2_m[MW-1:LW] * r_m2_mag[k];
            end
            r_n1_len <= r_m2_len;
            r_n1_str <= r_m2_str;
            r_n1_pos <= r_m2_pos;

            for (int k = 0; k < 3; k++) begin
                r_n2_num[k] <= NW'(r_n1_lo[k]) + (NW'(r_n1_hi[k]) << LW);
            end
            r_n2_len <= r_n1_len;
            r_n2_str <= r_n1_str;
            r_n2_pos <= r_n1_pos;
        end
    end

    assign o_job.num       = r_n2_num;
    assign o_job.pos       = r_n2_pos;
    assign o_job.len       = r_n2_len;
    assign o_job.stretched = r_n2_str;

endmodule

FILE: design/dsf_queue.sv
`timescale 1ns / 1ps
module dsf_queue import dsf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = r_cnt == (QAW+1)'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QAW'(1);
            if (i_pop)  r_rp <= r_rp + QAW'(1);
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");

endmodule

FILE: design/dsf_back.sv
`timescale 1ns / 1ps
module dsf_back import dsf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_job          i_job,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [FW-1:0] o_force_x,
    output logic [FW-1:0] o_force_y,
    output logic [FW-1:0] o_force_z,
    output logic          o_stretched,
    output logic          o_saturated
);

    localparam int DW = LW + FRAC_BITS;
    localparam int RW = DW + 1;
    localparam int CW = (NW > DW + QW + 1) ? NW : DW + QW + 1;

    logic en;
    logic [DW-1:0] w_den;

    logic                 r_d_v   [0:QW];
    logic [2:0][DW-1:0]   r_d_rem [0:QW];
    logic [2:0][QW-1:0]   r_d_low [0:QW];
    logic [2:0][QW-1:0]   r_d_q   [0:QW];
    logic [DW-1:0]        r_d_den [0:QW];
    logic [2:0]           r_d_ovf [0:QW];
    logic [2:0]           r_d_pos [0:QW];
    logic                 r_d_str [0:QW];

    logic [2:0][FW-1:0] w_val;
    logic [2:0]         w_sat;
    logic               w_big;
    logic [FW-1:0]      w_mag;

    logic               r_o_v;
    logic [2:0][FW-1:0] r_o_f;
    logic               r_o_str, r_o_sat;

    assign en    = !(r_o_v && !i_ready);
    assign o_pop = en && !i_empty;
    assign w_den = {i_job.len, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v[0] <= 1'b0;
        end else if (en) begin
            r_d_v[0] <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_d_ovf[0][k] <= CW'(i_job.num[k]) >= (CW'(w_den) << QW);
                r_d_rem[0][k] <= DW'(CW'(i_job.num[k]) >> QW);
                r_d_low[0][k] <= i_job.num[k][QW-1:0];
                r_d_q[0][k]   <= '0;
            end
            r_d_den[0] <= w_den;
            r_d_pos[0] <= i_job.pos;
            r_d_str[0] <= i_job.stretched;
        end
    end

    for (genvar i = 0; i < QW; i++) begin : g_div
        logic [2:0][RW-1:0] w_t;
        logic [2:0]         w_take;

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                w_t[k]    = {r_d_rem[i][k], r_d_low[i][k][QW-1-i]};
                w_take[k] = w_t[k] >= {1'b0, r_d_den[i]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_v[i+1] <= 1'b0;
            end else if (en) begin
                r_d_v[i+1] <= r_d_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int k = 0; k < 3; k++) begin
                    r_d_rem[i+1][k] <= w_take[k] ? DW'(w_t[k] - {1'b0, r_d_den[i]})
                                                 : DW'(w_t[k]);
                    r_d_q[i+1][k]   <= {r_d_q[i][k][QW-2:0], w_take[k]};
                end
                r_d_low[i+1] <= r_d_low[i];
                r_d_den[i+1] <= r_d_den[i];
                r_d_ovf[i+1] <= r_d_ovf[i];
                r_d_pos[i+1] <= r_d_pos[i];
                r_d_str[i+1] <= r_d_str[i];
            end
        end
    end

    always_comb begin
        w_big = 1'b0;
        w_mag = '0;
        for (int k = 0; k < 3; k++) begin
            if (r_d_pos[QW][k]) begin
                w_big    = r_d_ovf[QW][k] || (r_d_q[QW][k][FW-1] && (r_d_q[QW][k][FW-2:0] != '0));
                w_mag    = w_big ? {1'b1, {(FW-1){1'b0}}} : r_d_q[QW][k];
                w_val[k] = ~w_mag + FW'(1);
            end else begin
                w_big    = r_d_ovf[QW][k] || r_d_q[QW][k][FW-1];
                w_val[k] = w_big ? {1'b0, {(FW-1){1'b1}}} : r_d_q[QW][k];
            end
            w_sat[k] = w_big;
            if (!r_d_str[QW]) begin
                w_val[k] = '0;
                w_sat[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en) begin
            r_o_v <= r_d_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_f   <= w_val;
            r_o_str <= (w_val[0] != '0) || (w_val[1] != '0) || (w_val[2] != '0);
            r_o_sat <= |w_sat;
        end
    end

    assign o_valid     = r_o_v;
    assign o_force_x   = r_o_f[0];
    assign o_force_y   = r_o_f[1];
    assign o_force_z   = r_o_f[2];
    assign o_stretched = r_o_str;
    assign o_saturated = r_o_sat;

    a_slack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && !r_o_str) |-> (r_o_f == '0) && !r_o_sat)
        else $error("nonzero force on slack spring");

    a_sat_stretched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o_sat) |-> r_o_str)
        else $error("saturation without stretch");

endmodule

FILE: design/damped_spring_force_unit.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle when nothing stalls, set by the 34-stage
// square-root pipe and the 48-stage divider pipe, both fully pipelined.
// A 4-entry queue between the front and back pipes absorbs output stalls.
// Reset: synchronous, active low; clears all valid bits, the queue and the
// configuration registers to zero.
module damped_spring_force_unit import dsf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [CRDW-1:0] i_point_a_x,
    input  logic [CRDW-1:0] i_point_a_y,
    input  logic [CRDW-1:0] i_point_a_z,
    input  logic [CRDW-1:0] i_point_b_x,
    input  logic [CRDW-1:0] i_point_b_y,
    input  logic [CRDW-1:0] i_point_b_z,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [FW-1:0]   o_force_x,
    output logic [FW-1:0]   o_force_y,
    output logic [FW-1:0]   o_force_z,
    output logic            o_stretched,
    output logic            o_saturated,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data
);

    logic [31:0] r_ks, r_kd, r_rest;
    logic        push, pop, full, empty;
    t_job        job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks   <= '0;
            r_kd   <= '0;
            r_rest <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KS:   r_ks   <= i_cfg_data;
                CFG_KD:   r_kd   <= i_cfg_data;
                CFG_REST: r_rest <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dsf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_point_a_x (i_point_a_x),
        .i_point_a_y (i_point_a_y),
        .i_point_a_z (i_point_a_z),
        .i_point_b_x (i_point_b_x),
        .i_point_b_y (i_point_b_y),
        .i_point_b_z (i_point_b_z),
        .i_ks        (r_ks),
        .i_kd        (r_kd),
        .i_rest      (r_rest),
        .i_full      (full),
        .o_push      (push),
        .o_job       (job_in)
    );

    dsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (job_out)
    );

    dsf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_force_x   (o_force_x),
        .o_force_y   (o_force_y),
        .o_force_z   (o_force_z),
        .o_stretched (o_stretched),
        .o_saturated (o_saturated)
    );

endmodule
